// ----- hw/rtl/sorted_timer_queue_defines.svh -----
// ----------------------------------------------------------------------------
// Sorted timer queue assertion macros.
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SORTED_TIMER_QUEUE_DEFINES_SVH
`define SORTED_TIMER_QUEUE_DEFINES_SVH
`ifndef SYNTH
// Consequent must hold in the same cycle as the antecedent.
`define STQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define STQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define STQ_ASSERT_NOW(lbl, ante, cons, msg)
`define STQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/stq_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted timer queue package.
// Widths, codes and shared types of the timer queue and its cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package stq_pkg;

    localparam int TIMER_COUNT_DEF = 16;
    localparam int ID_LIMIT        = 16;
    localparam int ID_W            = 4;
    localparam int DL_W            = 32;
    localparam int DEST_W          = 8;
    localparam int WORD_W          = 32;
    localparam int FUNC_W          = 3;
    localparam int KIND_W          = 2;
    localparam int CFG_W           = 4;
    localparam int S_TDATA_W       = 80;
    localparam int M_TDATA_W       = 48;

    typedef enum logic [FUNC_W-1:0] {
        FN_TICK       = 3'd0,
        FN_ALLOC      = 3'd1,
        FN_FREE       = 3'd2,
        FN_BIND       = 3'd3,
        FN_ARM        = 3'd4,
        FN_CANCEL     = 3'd5,
        FN_CANCEL_ALL = 3'd6,
        FN_BAD        = 3'd7
    } t_func;

    typedef enum logic [1:0] {
        STAT_FREE  = 2'd0,
        STAT_ALLOC = 2'd1,
        STAT_RUN   = 2'd2
    } t_status;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACK    = 2'd0,
        KIND_EVENT  = 2'd1,
        KIND_SWITCH = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        Q_HOLD   = 2'd0,
        Q_INSERT = 2'd1,
        Q_REMOVE = 2'd2,
        Q_POP    = 2'd3
    } t_q_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_TICK,
        S_INSERT,
        S_SWEEP,
        S_ACK
    } t_state;

    // One position of the sorted list.
    typedef struct packed {
        logic            valid;
        logic [ID_W-1:0] id;
        logic [DL_W-1:0] dl;
    } t_slot;

    // Command broadcast to every cell of the list.
    typedef struct packed {
        t_q_op           op;
        logic [ID_W-1:0] id;
        logic [DL_W-1:0] dl;
    } t_q_ctl;

endpackage
`default_nettype wire

// ----- hw/rtl/stq_cell.sv -----
// ----------------------------------------------------------------------------
// Sorted timer queue cell.
// Holds one list position and shifts with its neighbors on insert, remove, pop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module stq_cell (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire stq_pkg::t_q_ctl i_ctl,
    input  wire stq_pkg::t_slot i_left,
    input  wire stq_pkg::t_slot i_right,
    input  wire logic           i_prev_ge,
    output logic                o_ge,
    input  wire logic           i_seen,
    output logic                o_seen,
    output stq_pkg::t_slot      o_slot
);
    import stq_pkg::*;

    t_slot r_slot;
    t_slot n_slot;
    logic  w_hit;

    // An empty cell stands for the sentinel, which is later than any deadline.
    assign o_ge   = !r_slot.valid || (r_slot.dl >= i_ctl.dl);
    assign w_hit  = r_slot.valid && (r_slot.id == i_ctl.id);
    assign o_seen = i_seen | w_hit;
    assign o_slot = r_slot;

    // Next content from the broadcast command and the neighbors.
    always_comb begin
        n_slot = r_slot;
        unique case (i_ctl.op)
            Q_HOLD: begin
                n_slot = r_slot;
            end
            Q_INSERT: begin
                if (i_prev_ge) begin
                    n_slot = i_left;
                end else if (o_ge) begin
                    n_slot.valid = 1'b1;
                    n_slot.id    = i_ctl.id;
                    n_slot.dl    = i_ctl.dl;
                end
            end
            Q_REMOVE: begin
                if (o_seen) begin
                    n_slot = i_right;
                end
            end
            Q_POP: begin
                n_slot = i_right;
            end
            default: begin
                n_slot = r_slot;
            end
        endcase
    end

    // Only the valid flag needs a reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.valid <= 1'b0;
        end else begin
            r_slot <= n_slot;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/stq_queue.sv -----
// ----------------------------------------------------------------------------
// Sorted timer queue list.
// A row of cells holding running timers in deadline order, earliest first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module stq_queue #(
    parameter int SLOTS = stq_pkg::TIMER_COUNT_DEF - 1
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire stq_pkg::t_q_ctl i_ctl,
    output stq_pkg::t_slot       o_head,
    output stq_pkg::t_slot       o_second
);
    import stq_pkg::*;

    t_slot w_slot [SLOTS+1];
    logic  w_ge   [SLOTS+1];
    logic  w_seen [SLOTS+1];

    // Beyond the last cell the list is empty.
    assign w_slot[SLOTS] = '0;
    assign w_ge[0]       = 1'b0;
    assign w_seen[0]     = 1'b0;

    // Chain of cells, each talking to its left and right neighbor only.
    for (genvar k = 0; k < SLOTS; k++) begin : g_cell
        t_slot w_left;
        if (k == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_rest
            assign w_left = w_slot[k-1];
        end
        stq_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (i_ctl),
            .i_left    (w_left),
            .i_right   (w_slot[k+1]),
            .i_prev_ge (w_ge[k]),
            .o_ge      (w_ge[k+1]),
            .i_seen    (w_seen[k]),
            .o_seen    (w_seen[k+1]),
            .o_slot    (w_slot[k])
        );
    end

    assign o_head   = w_slot[0];
    assign o_second = w_slot[1];

endmodule
`default_nettype wire

// ----- hw/rtl/sorted_timer_queue.sv -----
// ----------------------------------------------------------------------------
// Sorted timer queue.
// Pool of one-shot timers kept in a deadline-sorted list of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
// Commands enter on the s channel: tuser carries the function code, tdata the
// timer, delay, destination, data word and owned flag. Results leave on the m
// channel, one word per cycle at most, tuser the result kind, tlast set on the
// final word of a command. The cfg channel writes the switch timer and is always
// ready; that it is written only while the block is idle is left to the user.
// Allocate, free, bind and cancel go from the exec state to the ack state, arm
// by way of the insert state, cancel-all by way of the sweep state (one table
// entry inspected per cycle); a tick pops expired timers in the tick state. One
// command is in work at a time; the next is taken once the previous has placed
// its last word in the output register. List updates shift every cell at once.
// Reset empties the list, frees every timer but the sentinel, clears the tick
// count and the switch timer. When the receiver stalls, the output register
// holds its word and the sequencer waits before producing the next one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_timer_queue_defines.svh"
module sorted_timer_queue #(
    parameter int TIMER_COUNT = stq_pkg::TIMER_COUNT_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Command words.
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    // timer_id[3:0], delay_ticks[35:4], dest_id[43:36], event_data[75:44],
    // app_owned[76], zero padding[79:77].
    input  wire logic [stq_pkg::S_TDATA_W-1:0] i_s_tdata,
    // func[2:0].
    input  wire logic [stq_pkg::FUNC_W-1:0]    i_s_tuser,
    // Result words.
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    // out_timer[3:0], out_dest[11:4], out_data[43:12], ok[44], padding[47:45].
    output logic [stq_pkg::M_TDATA_W-1:0]      o_m_tdata,
    // kind[1:0].
    output logic [stq_pkg::KIND_W-1:0]         o_m_tuser,
    output logic                               o_m_tlast,
    // Switch timer register.
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [stq_pkg::CFG_W-1:0]     i_cfg_data
);
    import stq_pkg::*;

    localparam int ENTRIES = (TIMER_COUNT < ID_LIMIT) ? TIMER_COUNT : ID_LIMIT;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int SLOTS   = ENTRIES - 1;
    localparam logic [ID_W:0]    ENTRIES_W = (ID_W + 1)'(ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(ENTRIES - 1);

    // Sequencer and command registers.
    t_state            r_state, n_state;
    t_func             r_func, n_func;
    logic [ID_W-1:0]   r_id, n_id;
    logic              r_idok, n_idok;
    logic [DL_W-1:0]   r_dl, n_dl;
    logic [DEST_W-1:0] r_dest, n_dest;
    logic [WORD_W-1:0] r_word, n_word;
    logic              r_own, n_own;
    logic [DL_W-1:0]   r_tick, n_tick;
    logic [CFG_W-1:0]  r_sw, n_sw;
    logic              r_ts, n_ts;
    logic              r_emitted, n_emitted;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [ID_W-1:0]   r_ack_timer, n_ack_timer;
    logic              r_ack_ok, n_ack_ok;

    // Output register.
    logic              r_m_valid, n_m_valid;
    t_kind             r_m_kind, n_m_kind;
    logic [ID_W-1:0]   r_m_timer, n_m_timer;
    logic [DEST_W-1:0] r_m_dest, n_m_dest;
    logic [WORD_W-1:0] r_m_data, n_m_data;
    logic              r_m_ok, n_m_ok;
    logic              r_m_last, n_m_last;

    // Per-timer table.
    t_status           r_status [ENTRIES];
    logic              r_owned  [ENTRIES];
    logic [DEST_W-1:0] r_edest  [ENTRIES];
    logic [WORD_W-1:0] r_eword  [ENTRIES];

    logic              st_we;
    logic [IDX_W-1:0]  st_wa;
    t_status           st_wd;
    logic              own_we;
    logic [IDX_W-1:0]  own_wa;
    logic              own_wd;
    logic              bind_we;

    logic [IDX_W-1:0]  rd_idx;
    t_status           rd_status;
    logic              rd_owned;
    logic [DEST_W-1:0] rd_dest;
    logic [WORD_W-1:0] rd_word;

    logic              found_got;
    logic [ID_W-1:0]   found_id;

    t_q_ctl            q_ctl;
    t_slot             w_head;
    t_slot             w_second;

    logic              out_free;
    logic              head_due;
    logic              next_due;

    stq_queue #(
        .SLOTS (SLOTS)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (q_ctl),
        .o_head   (w_head),
        .o_second (w_second)
    );

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_m_valid;
    assign o_m_tdata   = {3'b000, r_m_ok, r_m_data, r_m_dest, r_m_timer};
    assign o_m_tuser   = r_m_kind;
    assign o_m_tlast   = r_m_last;

    assign out_free = !r_m_valid || i_m_tready;
    assign head_due = w_head.valid && (w_head.dl <= r_tick);
    assign next_due = w_second.valid && (w_second.dl <= r_tick);

    // Single table read port, addressed by the current step.
    always_comb begin
        unique case (r_state)
            S_TICK:  rd_idx = w_head.id[IDX_W-1:0];
            S_SWEEP: rd_idx = r_idx;
            default: rd_idx = r_id[IDX_W-1:0];
        endcase
    end

    assign rd_status = r_status[rd_idx];
    assign rd_owned  = r_owned[rd_idx];
    assign rd_dest   = r_edest[rd_idx];
    assign rd_word   = r_eword[rd_idx];

    // Lowest free timer for allocate.
    always_comb begin
        found_got = 1'b0;
        found_id  = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (!found_got && (r_status[i] == STAT_FREE)) begin
                found_got = 1'b1;
                found_id  = ID_W'(i);
            end
        end
    end

    // Sequencer: next state, table writes, list commands and result words.
    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_id        = r_id;
        n_idok      = r_idok;
        n_dl        = r_dl;
        n_dest      = r_dest;
        n_word      = r_word;
        n_own       = r_own;
        n_tick      = r_tick;
        n_sw        = r_sw;
        n_ts        = r_ts;
        n_emitted   = r_emitted;
        n_idx       = r_idx;
        n_ack_timer = r_ack_timer;
        n_ack_ok    = r_ack_ok;

        n_m_valid   = r_m_valid;
        n_m_kind    = r_m_kind;
        n_m_timer   = r_m_timer;
        n_m_dest    = r_m_dest;
        n_m_data    = r_m_data;
        n_m_ok      = r_m_ok;
        n_m_last    = r_m_last;

        q_ctl.op    = Q_HOLD;
        q_ctl.id    = r_id;
        q_ctl.dl    = r_dl;

        st_we       = 1'b0;
        st_wa       = r_id[IDX_W-1:0];
        st_wd       = STAT_FREE;
        own_we      = 1'b0;
        own_wa      = r_id[IDX_W-1:0];
        own_wd      = 1'b0;
        bind_we     = 1'b0;

        // A taken word leaves the output register unless replaced below.
        if (i_m_tready) begin
            n_m_valid = 1'b0;
        end

        if (i_cfg_valid) begin
            n_sw = i_cfg_data;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_func  = t_func'(i_s_tuser);
                    n_id    = i_s_tdata[3:0];
                    n_idok  = (i_s_tdata[3:0] != '0) && ({1'b0, i_s_tdata[3:0]} < ENTRIES_W);
                    n_dl    = r_tick + i_s_tdata[35:4];
                    n_dest  = i_s_tdata[43:36];
                    n_word  = i_s_tdata[75:44];
                    n_own   = i_s_tdata[76];
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_ack_timer = '0;
                n_ack_ok    = r_idok;
                n_state     = S_ACK;
                unique case (r_func)
                    FN_TICK: begin
                        n_tick    = r_tick + 1'b1;
                        n_ts      = 1'b0;
                        n_emitted = 1'b0;
                        n_state   = S_TICK;
                    end
                    FN_ALLOC: begin
                        n_ack_timer = found_id;
                        n_ack_ok    = found_got;
                        if (found_got) begin
                            st_we  = 1'b1;
                            st_wa  = found_id[IDX_W-1:0];
                            st_wd  = STAT_ALLOC;
                            own_we = 1'b1;
                            own_wa = found_id[IDX_W-1:0];
                            own_wd = 1'b0;
                        end
                    end
                    FN_FREE: begin
                        if (r_idok) begin
                            if (rd_status == STAT_RUN) begin
                                q_ctl.op = Q_REMOVE;
                            end
                            st_we = 1'b1;
                            st_wd = STAT_FREE;
                        end
                    end
                    FN_BIND: begin
                        if (r_idok) begin
                            bind_we = 1'b1;
                            own_we  = 1'b1;
                            own_wd  = r_own;
                        end
                    end
                    FN_ARM: begin
                        if (r_idok) begin
                            // A running timer is unlinked before its new insert.
                            if (rd_status == STAT_RUN) begin
                                q_ctl.op = Q_REMOVE;
                            end
                            st_we   = 1'b1;
                            st_wd   = STAT_RUN;
                            n_state = S_INSERT;
                        end
                    end
                    FN_CANCEL: begin
                        n_ack_ok = r_idok && (rd_status == STAT_RUN);
                        if (r_idok && (rd_status == STAT_RUN)) begin
                            q_ctl.op = Q_REMOVE;
                            st_we    = 1'b1;
                            st_wd    = STAT_ALLOC;
                        end
                    end
                    FN_CANCEL_ALL: begin
                        n_idx   = IDX_W'(1);
                        n_state = S_SWEEP;
                    end
                    default: begin
                        n_ack_ok = 1'b0;
                    end
                endcase
            end
            S_INSERT: begin
                q_ctl.op    = Q_INSERT;
                n_ack_timer = '0;
                n_ack_ok    = 1'b1;
                n_state     = S_ACK;
            end
            S_SWEEP: begin
                // One table entry per cycle, timers 1 and up.
                if ((rd_status != STAT_FREE) && rd_owned && (rd_dest == r_dest)) begin
                    if (rd_status == STAT_RUN) begin
                        q_ctl.op = Q_REMOVE;
                        q_ctl.id = ID_W'(r_idx);
                    end
                    st_we = 1'b1;
                    st_wa = r_idx;
                    st_wd = STAT_FREE;
                end
                n_idx = r_idx + 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_ack_timer = '0;
                    n_ack_ok    = 1'b1;
                    n_state     = S_ACK;
                end
            end
            S_TICK: begin
                if (head_due) begin
                    if (w_head.id == r_sw) begin
                        // The switch request goes out after every event.
                        q_ctl.op = Q_POP;
                        st_we    = 1'b1;
                        st_wa    = w_head.id[IDX_W-1:0];
                        st_wd    = STAT_ALLOC;
                        n_ts     = 1'b1;
                    end else if (out_free) begin
                        q_ctl.op  = Q_POP;
                        st_we     = 1'b1;
                        st_wa     = w_head.id[IDX_W-1:0];
                        st_wd     = STAT_ALLOC;
                        n_emitted = 1'b1;
                        n_m_valid = 1'b1;
                        n_m_kind  = KIND_EVENT;
                        n_m_timer = w_head.id;
                        n_m_dest  = rd_dest;
                        n_m_data  = rd_word;
                        n_m_ok    = 1'b1;
                        n_m_last  = !r_ts && !next_due;
                    end
                end else if (r_ts) begin
                    if (out_free) begin
                        n_m_valid = 1'b1;
                        n_m_kind  = KIND_SWITCH;
                        n_m_timer = r_sw;
                        n_m_dest  = '0;
                        n_m_data  = '0;
                        n_m_ok    = 1'b1;
                        n_m_last  = 1'b1;
                        n_state   = S_IDLE;
                    end
                end else if (!r_emitted) begin
                    if (out_free) begin
                        n_m_valid = 1'b1;
                        n_m_kind  = KIND_ACK;
                        n_m_timer = '0;
                        n_m_dest  = '0;
                        n_m_data  = '0;
                        n_m_ok    = 1'b1;
                        n_m_last  = 1'b1;
                        n_state   = S_IDLE;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_ACK: begin
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_m_kind  = KIND_ACK;
                    n_m_timer = r_ack_timer;
                    n_m_dest  = '0;
                    n_m_data  = '0;
                    n_m_ok    = r_ack_ok;
                    n_m_last  = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_tick    <= '0;
            r_sw      <= '0;
            r_ts      <= 1'b0;
            r_emitted <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_tick    <= n_tick;
            r_sw      <= n_sw;
            r_ts      <= n_ts;
            r_emitted <= n_emitted;
            r_m_valid <= n_m_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_func      <= n_func;
        r_id        <= n_id;
        r_idok      <= n_idok;
        r_dl        <= n_dl;
        r_dest      <= n_dest;
        r_word      <= n_word;
        r_own       <= n_own;
        r_idx       <= n_idx;
        r_ack_timer <= n_ack_timer;
        r_ack_ok    <= n_ack_ok;
        r_m_kind    <= n_m_kind;
        r_m_timer   <= n_m_timer;
        r_m_dest    <= n_m_dest;
        r_m_data    <= n_m_data;
        r_m_ok      <= n_m_ok;
        r_m_last    <= n_m_last;
    end

    // Status and owned flags; entry 0 is the sentinel and stays running.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                r_status[i] <= (i == 0) ? STAT_RUN : STAT_FREE;
                r_owned[i]  <= 1'b0;
            end
        end else begin
            if (st_we) begin
                r_status[st_wa] <= st_wd;
            end
            if (own_we) begin
                r_owned[own_wa] <= own_wd;
            end
        end
    end

    // Destination and data word, defined once bound.
    always_ff @(posedge i_clk) begin
        if (bind_we) begin
            r_edest[r_id[IDX_W-1:0]] <= r_dest;
            r_eword[r_id[IDX_W-1:0]] <= r_word;
        end
    end

    `STQ_ASSERT_NOW(a_head_not_sentinel, w_head.valid, w_head.id != '0, "sentinel in list")
    `STQ_ASSERT_NOW(a_list_sorted, w_head.valid && w_second.valid, w_head.dl <= w_second.dl, "list out of order")
    `STQ_ASSERT_NOW(a_switch_is_last, r_m_valid && (r_m_kind == KIND_SWITCH), r_m_last, "switch request not last")
    `STQ_ASSERT_NEXT(a_busy_after_accept, i_s_tvalid && o_s_tready, !o_s_tready, "second command taken")

endmodule
`default_nettype wire
